### design/uart_command_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// UART command frame parser assertion macros
// Shared concurrent assertion forms for the parser modules.
// ----------------------------------------------------------------------------
`ifndef UART_COMMAND_FRAME_PARSER_MACROS_SVH
`define UART_COMMAND_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define UCFP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define UCFP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/ucfp_pkg.sv
// ----------------------------------------------------------------------------
// UART command frame parser package
// Ring geometry, register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package ucfp_pkg;

  localparam int RING_DEPTH = 512;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int OUT_IDX_W  = 9;
  localparam int TDATA_W    = 32;

  localparam logic [15:0] KEY_HEADER_RESET  = 16'h2A20;
  localparam logic [15:0] DATA_HEADER_RESET = 16'h2A21;

  // Configuration register indexes
  localparam logic CFG_KEY_HEADER  = 1'b0;
  localparam logic CFG_DATA_HEADER = 1'b1;

  // Frame kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef logic [IDX_W-1:0] ring_idx_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_slot_t;

  typedef struct packed {
    logic                 kind;
    logic [OUT_IDX_W-1:0] frame_start;
    logic [OUT_IDX_W-1:0] frame_end;
    logic [7:0]           command_code;
  } frame_result_t;

  // Advance a ring index, wrapping at the ring depth
  function automatic ring_idx_t next_idx(input ring_idx_t i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // Reduce a ring index to the width of the output index fields
  function automatic logic [OUT_IDX_W-1:0] out_idx(input ring_idx_t i);
    logic [31:0] wide;
    wide = 32'(i);
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

### design/uart_command_frame_parser.sv
// ----------------------------------------------------------------------------
// UART command frame parser
// Frames received UART bytes and reports each completed command frame.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle unless the slave side stalls;
// the parse of a byte is a single state update between the input register
// and the result register, so a frame result is loaded there as its checksum
// byte leaves the input register. The slave side stalls only while a checksum
// byte waits behind a result that downstream has not yet taken. Ring positions
// are tracked as indexes only; byte storage is not kept, since nothing reads it.
// ----------------------------------------------------------------------------
module uart_command_frame_parser import ucfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] rx_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] frame_kind, [9:1] frame_start, [18:10] frame_end,
  // [26:19] command_code, [31:27] zero
  output logic [TDATA_W-1:0] m_axis_tdata
);

  rx_slot_t      slot;
  frame_result_t res;
  logic          res_pending;
  logic          can_load;
  logic          step;

  // Advance the held byte unless its result has nowhere to go
  assign step = slot.valid && (can_load || !res_pending);

  ucfp_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .step          (step),
    .slot          (slot)
  );

  ucfp_parse_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step        (step),
    .rx_byte     (slot.data),
    .res_pending (res_pending),
    .res         (res)
  );

  ucfp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_pending),
    .res           (res),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### design/ucfp_in_stage.sv
// ----------------------------------------------------------------------------
// UART command frame parser input stage
// Registers one received byte and hands it to the parse core.
// ----------------------------------------------------------------------------
module ucfp_in_stage import ucfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       step,
  output rx_slot_t   slot
);

  logic       in_valid;
  logic [7:0] in_byte;

  // Take a new transaction when empty or when the held byte is consumed
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  assign slot.valid = in_valid;
  assign slot.data  = in_byte;

endmodule

### design/ucfp_parse_core.sv
// ----------------------------------------------------------------------------
// UART command frame parser core
// Header match, frame phase tracking and ring index bookkeeping.
// ----------------------------------------------------------------------------
`include "uart_command_frame_parser_macros.svh"

module ucfp_parse_core import ucfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data,
  input  logic          step,
  input  logic [7:0]    rx_byte,
  output logic          res_pending,
  output frame_result_t res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_RW,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_CHECK
  } phase_t;

  logic [15:0] key_header_word;
  logic [15:0] data_header_word;

  phase_t     phase, phase_next;
  logic       header_pending, header_pending_next;
  logic [7:0] first_byte, first_byte_next;
  logic       matched_kind, matched_kind_next;
  logic [7:0] data_remaining, data_remaining_next;
  logic [7:0] saved_command, saved_command_next;
  ring_idx_t  write_index, write_index_next;
  ring_idx_t  frame_begin, frame_begin_next;

  ring_idx_t   wi_inc;
  ring_idx_t   wi_skip;
  logic [15:0] header_word;

  assign wi_inc      = next_idx(write_index);
  assign wi_skip     = next_idx(wi_inc);
  assign header_word = {first_byte, rx_byte};

  assign res_pending      = (phase == PH_CHECK);
  assign res.kind         = matched_kind;
  assign res.frame_start  = out_idx(frame_begin);
  assign res.frame_end    = out_idx(wi_inc);
  assign res.command_code = saved_command;

  always_comb begin
    phase_next          = phase;
    header_pending_next = header_pending;
    first_byte_next     = first_byte;
    matched_kind_next   = matched_kind;
    data_remaining_next = data_remaining;
    saved_command_next  = saved_command;
    write_index_next    = wi_inc;
    frame_begin_next    = frame_begin;
    case (phase)
      PH_RW: begin
        phase_next = PH_CMD;
      end
      PH_CMD: begin
        saved_command_next = rx_byte;
        phase_next         = PH_LEN;
      end
      PH_LEN: begin
        data_remaining_next = rx_byte;
        phase_next          = PH_DATA;
      end
      PH_DATA: begin
        // a zero length still takes one data byte
        if (data_remaining <= 8'd1) begin
          data_remaining_next = '0;
          phase_next          = PH_CHECK;
        end else begin
          data_remaining_next = data_remaining - 8'd1;
        end
      end
      PH_CHECK: begin
        // skip one slot and open the next frame there
        write_index_next = wi_skip;
        frame_begin_next = wi_skip;
        phase_next       = PH_HEADER;
      end
      default: begin
        phase_next = PH_HEADER;
        if (!header_pending) begin
          first_byte_next     = rx_byte;
          header_pending_next = 1'b1;
        end else begin
          header_pending_next = 1'b0;
          first_byte_next     = '0;
          if (header_word == key_header_word) begin
            matched_kind_next = KIND_KEY;
            phase_next        = PH_RW;
          end else if (header_word == data_header_word) begin
            matched_kind_next = KIND_DATA;
            phase_next        = PH_RW;
          end else begin
            // drop the unknown header
            write_index_next = wi_skip;
            frame_begin_next = wi_skip;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_header_word  <= KEY_HEADER_RESET;
      data_header_word <= DATA_HEADER_RESET;
      phase            <= PH_HEADER;
      header_pending   <= 1'b0;
      first_byte       <= '0;
      matched_kind     <= KIND_KEY;
      data_remaining   <= '0;
      saved_command    <= '0;
      write_index      <= '0;
      frame_begin      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_HEADER:  key_header_word  <= cfg_data;
          CFG_DATA_HEADER: data_header_word <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        phase          <= phase_next;
        header_pending <= header_pending_next;
        first_byte     <= first_byte_next;
        matched_kind   <= matched_kind_next;
        data_remaining <= data_remaining_next;
        saved_command  <= saved_command_next;
        write_index    <= write_index_next;
        frame_begin    <= frame_begin_next;
      end
    end
  end

  `UCFP_ASSERT_SAME(a_pending_in_header, clk, rst, header_pending, phase == PH_HEADER, "header byte pending outside header phase")
  `UCFP_ASSERT_NEXT(a_check_restarts, clk, rst, step && (phase == PH_CHECK), (frame_begin == write_index) && (phase == PH_HEADER), "frame did not restart after checksum")
  `UCFP_ASSERT_NEXT(a_data_ends, clk, rst, step && (phase == PH_DATA) && (data_remaining <= 8'd1), phase == PH_CHECK, "last data byte did not reach checksum phase")

endmodule

### design/ucfp_out_stage.sv
// ----------------------------------------------------------------------------
// UART command frame parser output stage
// Holds one finished frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ucfp_out_stage import ucfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  frame_result_t      res,
  output logic               can_load,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // [0] frame_kind, [9:1] frame_start, [18:10] frame_end,
  // [26:19] command_code, [31:27] zero
  output logic [TDATA_W-1:0] m_axis_tdata
);

  logic          out_valid;
  frame_result_t out_res;

  assign can_load = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_res.command_code, out_res.frame_end,
                          out_res.frame_start, out_res.kind};

endmodule
